@@ sv/rtnb_pkg.sv @@
package rtnb_pkg;

    localparam int LEAVES_MAX = 1024;
    localparam int ADDR_W     = $clog2(LEAVES_MAX);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int K_W        = CNT_W + 1;
    localparam int POS_W      = K_W + 1;
    localparam int KEY_BITS   = 32;
    localparam int PFX_W      = 8;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 24;

    localparam logic [CNT_W-1:0] LEAF_COUNT_RST = CNT_W'(2);

    typedef logic signed [PFX_W-1:0] t_pfx;

    localparam t_pfx PFX_NONE = -PFX_W'(1);

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_READ_I,
        SQ_LOAD_I,
        SQ_ISSUE,
        SQ_EVAL,
        SQ_DONE
    } t_seq_state;

    typedef enum logic [2:0] {
        PH_NEXT,
        PH_PREV,
        PH_EXPAND,
        PH_SEARCH,
        PH_NODE,
        PH_SPLIT
    } t_phase;

    typedef struct packed {
        logic              bad;
        logic [ADDR_W-1:0] node;
        logic [CNT_W-1:0]  n;
    } t_req;

    typedef struct packed {
        logic             bad;
        logic             right_is_leaf;
        logic [CNT_W-1:0] right_child;
        logic             left_is_leaf;
        logic [CNT_W-1:0] left_child;
    } t_res;

    function automatic logic [3:0] clz8(input logic [7:0] v);
        logic [3:0] r;
        r = 4'd8;
        for (int b = 0; b < 8; b++) begin
            if (v[b]) r = 4'(7 - b);
        end
        return r;
    endfunction

    function automatic logic [5:0] clz_key(input logic [KEY_BITS-1:0] v);
        logic [5:0] r;
        r = 6'(KEY_BITS);
        for (int k = 0; k < KEY_BITS / 8; k++) begin
            if (v[8*k +: 8] != 8'd0) r = 6'(8 * (KEY_BITS / 8 - 1 - k)) + {2'b00, clz8(v[8*k +: 8])};
        end
        return r;
    endfunction

endpackage

@@ sv/radix_tree_node_builder_top.sv @@
// Channel | Dir | Signals                              | Moves
// cfg     | in  | i_cfg_valid/o_cfg_ready/i_cfg_data   | leaf_count write
// s       | in  | i_s_tvalid/o_s_tready/tdata/tuser    | load or query item
// m       | out | o_m_tvalid/i_m_tready/tdata/tuser    | child result item
//
// A load into a store that is not full writes the code store directly.
// A query makes at most 3+3*log2(span) code-store probes, each an issue state and
// an evaluate state, plus the node fetch, the result and the return to idle; the
// single read port sets the pace. A refused item goes straight to the result.
// Reset clears the load pointer, sets leaf_count to 2 and empties the result slot.
// A waiting result stalls only the next query or refused load at its end; the
// input side takes a new item whenever the sequencer is idle.
module radix_tree_node_builder_top
    import rtnb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,   // leaf_count
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,    // sort key, node_index, zero pad
    input  logic             i_s_tuser,    // req_type
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,    // left_child, left_is_leaf, right_child, right_is_leaf
    output logic             o_m_tuser     // bad_request
);

    logic [CNT_W-1:0]    r_leaf_count;
    logic [CNT_W-1:0]    r_load_ptr;
    logic                r_m_valid;
    t_res                r_m_res;

    logic                accept, is_query, full, query_bad, wr_en, start;
    logic                seq_busy, seq_done, out_free, rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [KEY_BITS-1:0] rd_data;
    logic [KEY_BITS-1:0] code_in;
    logic [ADDR_W-1:0]   node_in;
    logic [CNT_W-1:0]    n_eff;
    t_req                req;
    t_res                seq_res;

    assign code_in  = i_s_tdata[KEY_BITS-1:0];
    assign node_in  = i_s_tdata[KEY_BITS +: ADDR_W];
    assign is_query = i_s_tuser;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !seq_busy;
    assign accept      = i_s_tvalid && o_s_tready;

    assign n_eff     = (r_leaf_count > CNT_W'(LEAVES_MAX)) ? CNT_W'(LEAVES_MAX) : r_leaf_count;
    assign full      = r_load_ptr >= CNT_W'(LEAVES_MAX);
    assign query_bad = (n_eff < CNT_W'(2)) || (({1'b0, node_in} + CNT_W'(1)) >= n_eff);

    assign wr_en    = accept && !is_query && !full;
    assign start    = accept && (is_query || full);
    assign req.bad  = is_query ? query_bad : 1'b1;
    assign req.node = node_in;
    assign req.n    = n_eff;

    assign out_free = !r_m_valid || i_m_tready;

    rtnb_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (LEAVES_MAX)
    ) u_code_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_load_ptr[ADDR_W-1:0]),
        .i_wr_data (code_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rtnb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (req),
        .i_out_free (out_free),
        .o_busy     (seq_busy),
        .o_done     (seq_done),
        .o_res      (seq_res),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= LEAF_COUNT_RST;
            r_load_ptr   <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_leaf_count <= i_cfg_data;
            if (wr_en) r_load_ptr <= r_load_ptr + CNT_W'(1);
            if (seq_done) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) r_m_res <= seq_res;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_res.right_is_leaf, r_m_res.right_child,
                         r_m_res.left_is_leaf, r_m_res.left_child};
    assign o_m_tuser  = r_m_res.bad;

endmodule

@@ sv/rtnb_ram.sv @@
module rtnb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/rtnb_prefix.sv @@
module rtnb_prefix
    import rtnb_pkg::*;
(
    input  logic [KEY_BITS-1:0] i_code_a,
    input  logic [KEY_BITS-1:0] i_code_b,
    input  logic [ADDR_W-1:0]   i_idx_a,
    input  logic [ADDR_W-1:0]   i_idx_b,
    input  logic                i_outside,
    output t_pfx                o_len
);

    logic [KEY_BITS-1:0] idx_xor;
    t_pfx                eq_len;
    t_pfx                ne_len;

    assign idx_xor = {{(KEY_BITS - ADDR_W){1'b0}}, i_idx_a ^ i_idx_b};
    assign eq_len  = PFX_W'(KEY_BITS) + PFX_W'(clz_key(idx_xor));
    assign ne_len  = PFX_W'(clz_key(i_code_a ^ i_code_b));

    assign o_len = i_outside ? PFX_NONE : ((i_code_a == i_code_b) ? eq_len : ne_len);

endmodule

@@ sv/rtnb_seq.sv @@
module rtnb_seq
    import rtnb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_req                i_req,
    input  logic                i_out_free,
    output logic                o_busy,
    output logic                o_done,
    output t_res                o_res,
    output logic                o_rd_en,
    output logic [ADDR_W-1:0]   o_rd_addr,
    input  logic [KEY_BITS-1:0] i_rd_data
);

    t_seq_state          r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [ADDR_W-1:0]   r_node, n_node;
    logic [CNT_W-1:0]    r_n, n_n;
    logic                r_bad, n_bad;
    logic [KEY_BITS-1:0] r_ci, n_ci;
    logic [K_W-1:0]      r_k, n_k;
    logic                r_dneg, n_dneg;
    logic [ADDR_W-1:0]   r_pos_idx, n_pos_idx;
    logic                r_oor, n_oor;
    t_pfx                r_pa, n_pa;
    t_pfx                r_thr, n_thr;
    logic [K_W-1:0]      r_l, n_l;
    logic [K_W-1:0]      r_s, n_s;
    logic [K_W-1:0]      r_t, n_t;

    logic [POS_W-1:0]    node_p, k_p, n_p, pos;
    logic                pos_oor;
    t_pfx                plen;
    logic                gt;
    logic [K_W-1:0]      l_next, s_next, t_shr, t_ceil, l_half;
    logic [K_W-1:0]      node_k, gamma, gamma1, j_pos, lo, hi;
    logic                left_leaf, right_leaf;

    rtnb_prefix u_prefix (
        .i_code_a  (r_ci),
        .i_code_b  (i_rd_data),
        .i_idx_a   (r_node),
        .i_idx_b   (r_pos_idx),
        .i_outside (r_oor),
        .o_len     (plen)
    );

    assign node_p  = {{(POS_W - ADDR_W){1'b0}}, r_node};
    assign k_p     = {1'b0, r_k};
    assign n_p     = {{(POS_W - CNT_W){1'b0}}, r_n};
    assign pos     = r_dneg ? (node_p - k_p) : (node_p + k_p);
    assign pos_oor = pos[POS_W-1] || (pos >= n_p);

    assign gt     = plen > r_thr;
    assign l_next = gt ? (r_l + r_t) : r_l;
    assign s_next = gt ? (r_s + r_t) : r_s;
    assign t_shr  = r_t >> 1;
    assign t_ceil = (r_t + K_W'(1)) >> 1;
    assign l_half = (r_l + K_W'(1)) >> 1;

    assign node_k     = {{(K_W - ADDR_W){1'b0}}, r_node};
    assign gamma      = r_dneg ? (node_k - r_s - K_W'(1)) : (node_k + r_s);
    assign gamma1     = gamma + K_W'(1);
    assign j_pos      = r_dneg ? (node_k - r_l) : (node_k + r_l);
    assign lo         = r_dneg ? j_pos : node_k;
    assign hi         = r_dneg ? node_k : j_pos;
    assign left_leaf  = lo == gamma;
    assign right_leaf = hi == gamma1;

    always_comb begin
        if (r_bad) begin
            o_res     = '0;
            o_res.bad = 1'b1;
        end else begin
            o_res.bad           = 1'b0;
            o_res.left_is_leaf  = left_leaf;
            o_res.right_is_leaf = right_leaf;
            o_res.left_child    = left_leaf ? gamma[CNT_W-1:0] : (r_n + gamma[CNT_W-1:0]);
            o_res.right_child   = right_leaf ? gamma1[CNT_W-1:0] : (r_n + gamma1[CNT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_phase <= PH_NEXT;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node    <= n_node;
        r_n       <= n_n;
        r_bad     <= n_bad;
        r_ci      <= n_ci;
        r_k       <= n_k;
        r_dneg    <= n_dneg;
        r_pos_idx <= n_pos_idx;
        r_oor     <= n_oor;
        r_pa      <= n_pa;
        r_thr     <= n_thr;
        r_l       <= n_l;
        r_s       <= n_s;
        r_t       <= n_t;
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_node    = r_node;
        n_n       = r_n;
        n_bad     = r_bad;
        n_ci      = r_ci;
        n_k       = r_k;
        n_dneg    = r_dneg;
        n_pos_idx = r_pos_idx;
        n_oor     = r_oor;
        n_pa      = r_pa;
        n_thr     = r_thr;
        n_l       = r_l;
        n_s       = r_s;
        n_t       = r_t;
        o_rd_en   = 1'b0;
        o_rd_addr = r_node;
        o_done    = 1'b0;

        unique case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    n_node  = i_req.node;
                    n_n     = i_req.n;
                    n_bad   = i_req.bad;
                    n_state = i_req.bad ? SQ_DONE : SQ_READ_I;
                end
            end
            SQ_READ_I: begin
                o_rd_en = 1'b1;
                n_state = SQ_LOAD_I;
            end
            SQ_LOAD_I: begin
                n_ci    = i_rd_data;
                n_phase = PH_NEXT;
                n_k     = K_W'(1);
                n_dneg  = 1'b0;
                n_state = SQ_ISSUE;
            end
            SQ_ISSUE: begin
                o_rd_en   = !pos_oor;
                o_rd_addr = pos[ADDR_W-1:0];
                n_pos_idx = pos[ADDR_W-1:0];
                n_oor     = pos_oor;
                n_state   = SQ_EVAL;
            end
            SQ_EVAL: begin
                n_state = SQ_ISSUE;
                unique case (r_phase)
                    PH_NEXT: begin
                        n_pa    = plen;
                        n_k     = K_W'(1);
                        n_dneg  = 1'b1;
                        n_phase = PH_PREV;
                    end
                    PH_PREV: begin
                        n_dneg  = !(r_pa > plen);
                        n_thr   = (r_pa > plen) ? plen : r_pa;
                        n_k     = K_W'(2);
                        n_phase = PH_EXPAND;
                    end
                    PH_EXPAND: begin
                        if (gt) begin
                            n_k = r_k << 1;
                        end else begin
                            n_l     = '0;
                            n_t     = r_k >> 1;
                            n_k     = r_k >> 1;
                            n_phase = PH_SEARCH;
                        end
                    end
                    PH_SEARCH: begin
                        n_l = l_next;
                        n_t = t_shr;
                        if (t_shr == '0) begin
                            n_k     = l_next;
                            n_phase = PH_NODE;
                        end else begin
                            n_k = l_next + t_shr;
                        end
                    end
                    PH_NODE: begin
                        n_thr   = plen;
                        n_s     = '0;
                        n_t     = l_half;
                        n_k     = l_half;
                        n_phase = PH_SPLIT;
                        if (l_half == '0) n_state = SQ_DONE;
                    end
                    PH_SPLIT: begin
                        n_s = s_next;
                        if (r_t == K_W'(1)) begin
                            n_state = SQ_DONE;
                        end else begin
                            n_t = t_ceil;
                            n_k = s_next + t_ceil;
                        end
                    end
                    default: n_state = SQ_DONE;
                endcase
            end
            SQ_DONE: begin
                o_done = i_out_free;
                if (i_out_free) n_state = SQ_IDLE;
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    assign o_busy = r_state != SQ_IDLE;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == SQ_IDLE)
        else $error("start while sequencer busy");

    a_eval_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == SQ_EVAL |-> $past(r_state) == SQ_ISSUE)
        else $error("evaluation without a probe");

    a_read_for_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_EVAL && !r_oor) |-> $past(o_rd_en))
        else $error("probe evaluated without a code read");

    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_ISSUE && (r_phase == PH_SEARCH || r_phase == PH_SPLIT))
            |-> r_t != '0)
        else $error("search step collapsed to zero");

endmodule

@@ test/radix_node_checker.sv @@
`timescale 1ns / 1ps

package rtnb_tb_pkg;
    typedef enum logic {
        REQ_LOAD,
        REQ_QUERY
    } t_req_kind;
endpackage

module radix_node_checker
    import rtnb_pkg::*;
    import rtnb_tb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_s_tuser,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,
    input  logic             i_m_tuser,
    output int               o_fail_count,
    output int               o_pending
);

    logic [KEY_BITS-1:0] code_copy [LEAVES_MAX];
    logic [CNT_W-1:0]    fill_ptr;
    logic [CNT_W-1:0]    leaf_cfg;
    t_res                children_q [$];

    function automatic int count_lead_zeros(input logic [KEY_BITS-1:0] v);
        int k;
        for (k = KEY_BITS - 1; k >= 0; k--) begin
            if (v[k]) begin
                return KEY_BITS - 1 - k;
            end
        end
        return KEY_BITS;
    endfunction

    // -1 when either position lies outside the leaves
    function automatic int shared_prefix(input int a, input int b, input int n);
        logic [KEY_BITS-1:0] diff;
        if (a < 0 || b < 0 || a >= n || b >= n) begin
            return -1;
        end
        if (code_copy[a] == code_copy[b]) begin
            diff = KEY_BITS'(a ^ b);
            return KEY_BITS + count_lead_zeros(diff);
        end
        return count_lead_zeros(code_copy[a] ^ code_copy[b]);
    endfunction

    function automatic t_res resolve_node(input logic [ADDR_W-1:0] node);
        t_res r;
        int   n, i, d, dmin, lmax, l, t, j, dnode, s, gamma, lo, hi;
        logic left_leaf, right_leaf;
        r = '0;
        n = (int'(leaf_cfg) > LEAVES_MAX) ? LEAVES_MAX : int'(leaf_cfg);
        i = int'(node);
        if (n < 2 || i >= n - 1) begin
            r.bad = 1'b1;
            return r;
        end
        d    = (shared_prefix(i, i + 1, n) > shared_prefix(i, i - 1, n)) ? 1 : -1;
        dmin = shared_prefix(i, i - d, n);
        lmax = 2;
        while (shared_prefix(i, i + lmax * d, n) > dmin) begin
            lmax = lmax * 2;
        end
        l = 0;
        for (t = lmax / 2; t >= 1; t = t / 2) begin
            if (shared_prefix(i, i + (l + t) * d, n) > dmin) begin
                l = l + t;
            end
        end
        j     = i + l * d;
        dnode = shared_prefix(i, j, n);
        s     = 0;
        t     = (l + 1) / 2;
        while (t >= 1) begin
            if (shared_prefix(i, i + (s + t) * d, n) > dnode) begin
                s = s + t;
            end
            t = (t == 1) ? 0 : (t + 1) / 2;
        end
        gamma      = i + s * d + ((d < 0) ? -1 : 0);
        lo         = (i < j) ? i : j;
        hi         = (i < j) ? j : i;
        left_leaf  = (lo == gamma);
        right_leaf = (hi == gamma + 1);
        r.left_child    = CNT_W'(left_leaf ? gamma : n + gamma);
        r.left_is_leaf  = left_leaf;
        r.right_child   = CNT_W'(right_leaf ? gamma + 1 : n + gamma + 1);
        r.right_is_leaf = right_leaf;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            fill_ptr = '0;
            leaf_cfg = LEAF_COUNT_RST;
            children_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                leaf_cfg = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_req_kind'(i_s_tuser) == REQ_QUERY) begin
                    want       = resolve_node(i_s_tdata[KEY_BITS +: ADDR_W]);
                    children_q = {children_q, want};
                end else if (int'(fill_ptr) >= LEAVES_MAX) begin
                    want       = '0;
                    want.bad   = 1'b1;
                    children_q = {children_q, want};
                end else begin
                    code_copy[fill_ptr[ADDR_W-1:0]] = i_s_tdata[KEY_BITS-1:0];
                    fill_ptr = fill_ptr + CNT_W'(1);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tuser, i_m_tdata};
                if (children_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: unexpected result %h", $realtime, got);
                    end
                    o_fail_count++;
                end else begin
                    want = children_q.pop_front();
                    if (got.left_child !== want.left_child
                        || got.left_is_leaf !== want.left_is_leaf
                        || got.right_child !== want.right_child
                        || got.right_is_leaf !== want.right_is_leaf
                        || got.bad !== want.bad) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: mismatch exp L=%0d/%b R=%0d/%b bad=%b",
                                     $realtime, want.left_child, want.left_is_leaf,
                                     want.right_child, want.right_is_leaf, want.bad);
                            $display("%0t:          got L=%0d/%b R=%0d/%b bad=%b",
                                     $realtime, got.left_child, got.left_is_leaf,
                                     got.right_child, got.right_is_leaf, got.bad);
                        end
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = children_q.size();
    end

endmodule

@@ test/tb_radix_tree_node_builder_top.sv @@
`timescale 1ns / 1ps

module tb_radix_tree_node_builder_top;
    import rtnb_pkg::*;
    import rtnb_tb_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYC   = 7;
    localparam int PHASES      = 11;
    localparam int CHUNK       = 170;
    localparam int QUERIES     = 56;
    localparam int SETTLE_CYC  = 64;
    localparam int STALL_LIMIT = 4000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready = 1'b1;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    int               fail_count;
    int               pending;
    int               quiet_cycles = 0;

    t_idle_mode          idle_mode = IDLE_NONE;
    logic [KEY_BITS-1:0] leaf_codes [LEAVES_MAX];
    int                  loaded = 0;
    int                  cur_leaf = 2;

    always #HALF_PERIOD clk = ~clk;

    radix_tree_node_builder_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    radix_node_checker child_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        case (idle_mode)
            IDLE_RECV: m_tready = ($urandom_range(0, 99) >= 68);
            IDLE_BOTH: m_tready = ($urandom_range(0, 99) >= 6);
            default:   m_tready = 1'b1;
        endcase
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input t_req_kind kind, input logic [KEY_BITS-1:0] code,
                             input logic [ADDR_W-1:0] node);
        while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 68)
               || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 6)) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = IN_W'({node, code});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // past a full store the code is noise and the load is refused
    task automatic load_next_code();
        logic [KEY_BITS-1:0] code;
        code = (loaded < LEAVES_MAX) ? leaf_codes[loaded] : KEY_BITS'($urandom);
        send_item(REQ_LOAD, code, ADDR_W'($urandom_range(0, 1023)));
        loaded++;
    endtask

    task automatic query_node(input logic [ADDR_W-1:0] node);
        send_item(REQ_QUERY, KEY_BITS'($urandom), node);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_leaf_count(input int value);
        cfg_valid = 1'b1;
        cfg_data  = CNT_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cur_leaf  = value;
    endtask

    function automatic logic [ADDR_W-1:0] pick_node();
        int n, r;
        n = (cur_leaf > LEAVES_MAX) ? LEAVES_MAX : cur_leaf;
        r = $urandom_range(0, 99);
        if (n < 2) begin
            return ADDR_W'($urandom_range(0, 1023));
        end
        if (r < 5) begin
            return '0;
        end
        if (r < 10) begin
            return ADDR_W'(n - 2);
        end
        if (r < 16) begin
            return ADDR_W'($urandom_range(n - 1, 1023));
        end
        return ADDR_W'($urandom_range(0, n - 2));
    endfunction

    function automatic int leaf_setting(input int phase);
        int avail;
        avail = (loaded > LEAVES_MAX) ? LEAVES_MAX : loaded;
        case (phase)
            1:       return 2;
            2, 4, 8: return $urandom_range(2, avail);
            6:       return 2047;
            7:       return 1025;
            9:       return 1;
            default: return avail;
        endcase
    endfunction

    initial begin
        longint acc;
        int     r, k, phase, q;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;

        // sorted codes with runs of equal values and the odd out-of-order one
        leaf_codes[0] = '0;
        leaf_codes[1] = '0;
        leaf_codes[2] = KEY_BITS'(7);
        leaf_codes[3] = KEY_BITS'(7);
        leaf_codes[4] = KEY_BITS'(7);
        acc = 7;
        for (k = 5; k < LEAVES_MAX - 1; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                acc = acc;
            end else if (r < 35) begin
                acc = acc + $urandom_range(1, 15);
            end else begin
                acc = acc + $urandom_range(0, 8000000);
            end
            if (acc > 64'hFFFF_FFFF) begin
                acc = 64'hFFFF_FFFF;
            end
            leaf_codes[k] = ($urandom_range(0, 99) < 2) ? KEY_BITS'($urandom) : KEY_BITS'(acc);
        end
        leaf_codes[LEAVES_MAX-1] = '1;

        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        query_node(ADDR_W'(1));
        query_node('1);
        load_next_code();
        load_next_code();
        query_node('0);
        drain_results();
        write_leaf_count(0);
        query_node('0);
        drain_results();
        write_leaf_count(1);
        query_node('0);
        repeat (6) load_next_code();
        drain_results();
        write_leaf_count(8);
        for (k = 0; k < 8; k++) begin
            query_node(ADDR_W'(k));
        end

        for (phase = 0; phase < PHASES; phase++) begin
            idle_mode = t_idle_mode'(phase % 4);
            for (k = 0; k < CHUNK && loaded < LEAVES_MAX; k++) begin
                load_next_code();
            end
            drain_results();
            write_leaf_count(leaf_setting(phase));
            for (q = 0; q < QUERIES; q++) begin
                if (q == QUERIES / 2) begin
                    drain_results();
                end
                if (loaded >= LEAVES_MAX && $urandom_range(0, 99) < 8) begin
                    load_next_code();
                end else begin
                    query_node(pick_node());
                end
            end
        end

        idle_mode = IDLE_NONE;
        drain_results();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
